>>> hw/rtl/ctb_pkg.sv
// Shared types and constants for the cursor text buffer.
// Used by ctb_ctrl, ctb_datapath and cursor_text_buffer; no dependencies.
`default_nettype none

package ctb_pkg;

  localparam int CAPACITY_DEF = 1024;

  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] K_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] K_LEFT   = 3'd1;
  localparam logic [KIND_W-1:0] K_RIGHT  = 3'd2;
  localparam logic [KIND_W-1:0] K_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] K_READ   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch item, read memory
    logic exec;     // write memory, update counts, load result
  } ctb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } ctb_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/cursor_text_buffer.sv
// Cursor text buffer: gap-buffer line editor, top level.
// Depends on ctb_pkg, ctb_ctrl and ctb_datapath.
//
// Each item is handled in a capture and an execute step: at acceptance the
// single-port text memory is read for the byte that a cursor move carries or a
// read returns, and in the execute step that byte is written across the gap,
// the counts update and the result is loaded into the output register. A new
// item is taken as soon as the previous one has been loaded, even while its
// result waits; a result register that is still full holds the execute step
// until the consumer takes it. The memory needs no clearing after reset, so
// the block accepts items as soon as reset is released.
`default_nettype none

module cursor_text_buffer #(
  parameter int CAPACITY = ctb_pkg::CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [ctb_pkg::KIND_W-1:0] in_kind,
  input  wire logic [ctb_pkg::CHAR_W-1:0] in_char_in,
  input  wire logic [ctb_pkg::IDX_W-1:0]  in_read_index,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [ctb_pkg::CHAR_W-1:0]      out_char_out,
  output logic [ctb_pkg::CNT_W-1:0]       out_text_length,
  output logic [ctb_pkg::CNT_W-1:0]       out_cursor_pos,
  output logic [ctb_pkg::STAT_W-1:0]      out_status
);

  ctb_pkg::ctb_cmd_t  cmd;
  ctb_pkg::ctb_stat_t stat;

  ctb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ctb_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_char_in      (in_char_in),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_out    (out_char_out),
    .out_text_length (out_text_length),
    .out_cursor_pos  (out_cursor_pos),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

>>> hw/rtl/ctb_ctrl.sv
// Controller state machine for the cursor text buffer.
// Depends on ctb_pkg; drives ctb_datapath through ctb_cmd_t.
`default_nettype none

module ctb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output ctb_pkg::ctb_cmd_t      cmd,
  input  wire ctb_pkg::ctb_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ctb_datapath.sv
// Datapath for the cursor text buffer: gap memory, cursor counts, result register.
// Depends on ctb_pkg; controlled by ctb_ctrl.
`default_nettype none

module ctb_datapath #(
  parameter int CAPACITY = ctb_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ctb_pkg::ctb_cmd_t           cmd,
  output ctb_pkg::ctb_stat_t               stat,
  input  wire logic [ctb_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [ctb_pkg::CHAR_W-1:0]  in_char_in,
  input  wire logic [ctb_pkg::IDX_W-1:0]   in_read_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ctb_pkg::CHAR_W-1:0]       out_char_out,
  output logic [ctb_pkg::CNT_W-1:0]        out_text_length,
  output logic [ctb_pkg::CNT_W-1:0]        out_cursor_pos,
  output logic [ctb_pkg::STAT_W-1:0]       out_status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > ctb_pkg::IDX_W) ? CW : ctb_pkg::IDX_W;
  localparam int SW = MW + 1;
  localparam int OW = (CW > ctb_pkg::CNT_W) ? CW : ctb_pkg::CNT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);

  logic [ctb_pkg::CHAR_W-1:0] mem [CAPACITY];

  logic [CW-1:0] left_r, left_nxt, right_r, right_nxt, total, total_nxt;
  logic          full;
  logic [ctb_pkg::KIND_W-1:0] kind_r;
  logic [ctb_pkg::CHAR_W-1:0] char_r;
  logic [ctb_pkg::IDX_W-1:0]  idx_r;

  logic [SW-1:0] left_s, right_s, in_idx_s, idx_s, total_s, rd_addr_s, wr_addr_s;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [ctb_pkg::CHAR_W-1:0] rd_data_r, wr_data, rd_byte;
  logic          wr_en;
  logic [ctb_pkg::STAT_W-1:0] status_nxt;
  logic [OW-1:0] len_w, cur_w;

  logic                       out_valid_r;
  logic [ctb_pkg::CHAR_W-1:0] out_char_r;
  logic [ctb_pkg::CNT_W-1:0]  out_len_r, out_cur_r;
  logic [ctb_pkg::STAT_W-1:0] out_status_r;

  assign total    = left_r + right_r;
  assign full     = (total >= CAP_C);
  assign left_s   = SW'(left_r);
  assign right_s  = SW'(right_r);
  assign total_s  = SW'(total);
  assign in_idx_s = SW'(in_read_index);
  assign idx_s    = SW'(idx_r);

  // read address for the incoming item, counts are current at accept time
  always_comb begin
    case (in_kind)
      ctb_pkg::K_LEFT:  rd_addr_s = left_s - 1'b1;
      ctb_pkg::K_RIGHT: rd_addr_s = CAP_S - right_s;
      ctb_pkg::K_READ:  rd_addr_s = (in_idx_s < left_s) ? in_idx_s
                                    : in_idx_s - left_s + CAP_S - right_s;
      default:          rd_addr_s = in_idx_s;
    endcase
  end
  assign rd_addr = rd_addr_s[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data_r <= mem[rd_addr];
      kind_r    <= in_kind;
      char_r    <= in_char_in;
      idx_r     <= in_read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    left_nxt   = left_r;
    right_nxt  = right_r;
    wr_en      = 1'b0;
    wr_addr_s  = left_s;
    wr_data    = rd_data_r;
    rd_byte    = '0;
    status_nxt = ctb_pkg::ST_DONE;
    case (kind_r)
      ctb_pkg::K_INSERT: begin
        if (full) begin
          status_nxt = ctb_pkg::ST_FULL;
        end else begin
          wr_en    = cmd.exec;
          wr_data  = char_r;
          left_nxt = left_r + 1'b1;
        end
      end
      ctb_pkg::K_LEFT: begin
        if (left_r == '0) begin
          status_nxt = ctb_pkg::ST_IGNORED;
        end else begin
          wr_en     = cmd.exec;
          wr_addr_s = CAP_S - right_s - 1'b1;
          left_nxt  = left_r - 1'b1;
          right_nxt = right_r + 1'b1;
        end
      end
      ctb_pkg::K_RIGHT: begin
        if (right_r == '0) begin
          status_nxt = ctb_pkg::ST_IGNORED;
        end else begin
          wr_en     = cmd.exec;
          left_nxt  = left_r + 1'b1;
          right_nxt = right_r - 1'b1;
        end
      end
      ctb_pkg::K_BACK: begin
        if (left_r == '0) begin
          status_nxt = ctb_pkg::ST_IGNORED;
        end else begin
          left_nxt = left_r - 1'b1;
        end
      end
      ctb_pkg::K_READ: begin
        if (idx_s >= total_s) begin
          status_nxt = ctb_pkg::ST_RANGE;
        end else begin
          rd_byte = rd_data_r;
        end
      end
      default: status_nxt = ctb_pkg::ST_IGNORED;
    endcase
  end

  assign wr_addr   = wr_addr_s[AW-1:0];
  assign total_nxt = left_nxt + right_nxt;
  assign len_w     = OW'(total_nxt);
  assign cur_w     = OW'(left_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (cmd.exec) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_char_r   <= rd_byte;
      out_len_r    <= len_w[ctb_pkg::CNT_W-1:0];
      out_cur_r    <= cur_w[ctb_pkg::CNT_W-1:0];
      out_status_r <= status_nxt;
    end
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_text_length = out_len_r;
  assign out_cursor_pos  = out_cur_r;
  assign out_status      = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + 1)'(left_r) + (CW + 1)'(right_r) <= (CW + 1)'(CAPACITY))
    else $error("text count exceeds capacity");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.exec))
    else $error("capture and exec in the same cycle");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("exec did not load a result");

  a_insert_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && kind_r == ctb_pkg::K_INSERT && !full)
      |=> (left_r == CW'($past(left_r) + 1'b1)) && $stable(right_r))
    else $error("insert did not advance the cursor");

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench for cursor_text_buffer: a directed command table and segmented random edits,
// every result checked against the table's values or a gap-buffer predictor held here.
// Depends on ctb_pkg and the cursor_text_buffer RTL.
module tb;

  localparam int CAP = ctb_pkg::CAPACITY_DEF;
  localparam int N_RAND = 850;

  // kind codes the block leaves unused
  localparam logic [ctb_pkg::KIND_W-1:0] K_SPARE_LO  = 3'd5;
  localparam logic [ctb_pkg::KIND_W-1:0] K_SPARE_MID = 3'd6;
  localparam logic [ctb_pkg::KIND_W-1:0] K_SPARE_HI  = 3'd7;

  typedef enum int {M_GROW, M_EDIT, M_SHRINK, M_SCAN} edit_mix_t;

  typedef struct packed {
    logic [ctb_pkg::CHAR_W-1:0] ch;
    logic [ctb_pkg::CNT_W-1:0]  len;
    logic [ctb_pkg::CNT_W-1:0]  cur;
    logic [ctb_pkg::STAT_W-1:0] st;
  } line_res_t;

  typedef struct packed {
    logic [ctb_pkg::KIND_W-1:0] kind;
    logic [ctb_pkg::CHAR_W-1:0] ch;
    logic [ctb_pkg::IDX_W-1:0]  idx;
    logic                       known;
    line_res_t                  res;
  } cmd_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [ctb_pkg::KIND_W-1:0] in_kind;
  logic [ctb_pkg::CHAR_W-1:0] in_char_in;
  logic [ctb_pkg::IDX_W-1:0]  in_read_index;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [ctb_pkg::CHAR_W-1:0] out_char_out;
  logic [ctb_pkg::CNT_W-1:0]  out_text_length;
  logic [ctb_pkg::CNT_W-1:0]  out_cursor_pos;
  logic [ctb_pkg::STAT_W-1:0] out_status;

  logic [ctb_pkg::CHAR_W-1:0] text_mem [CAP];
  int unsigned                left_n;
  int unsigned                right_n;
  line_res_t                  pending_lines [$];
  int                         err_count = 0;
  int                         tx_max = 6;
  int                         rx_max = 6;
  int                         rx_wait = 0;
  logic                       rx_took = 1'b0;

  cmd_row_t dir_rows [25] = '{
    '{ctb_pkg::K_LEFT,   8'h00, 10'd0,    1'b1, '{8'h00, 11'd0, 11'd0, ctb_pkg::ST_IGNORED}},
    '{ctb_pkg::K_BACK,   8'h00, 10'd0,    1'b1, '{8'h00, 11'd0, 11'd0, ctb_pkg::ST_IGNORED}},
    '{ctb_pkg::K_RIGHT,  8'h00, 10'd0,    1'b1, '{8'h00, 11'd0, 11'd0, ctb_pkg::ST_IGNORED}},
    '{ctb_pkg::K_READ,   8'h00, 10'd0,    1'b1, '{8'h00, 11'd0, 11'd0, ctb_pkg::ST_RANGE}},
    '{K_SPARE_LO,        8'h00, 10'd0,    1'b1, '{8'h00, 11'd0, 11'd0, ctb_pkg::ST_IGNORED}},
    '{K_SPARE_MID,       8'hFF, 10'd1023, 1'b1, '{8'h00, 11'd0, 11'd0, ctb_pkg::ST_IGNORED}},
    '{K_SPARE_HI,        8'h00, 10'd0,    1'b1, '{8'h00, 11'd0, 11'd0, ctb_pkg::ST_IGNORED}},
    '{ctb_pkg::K_INSERT, "P",   10'd0,    1'b1, '{8'h00, 11'd1, 11'd1, ctb_pkg::ST_DONE}},
    '{ctb_pkg::K_INSERT, "L",   10'd0,    1'b1, '{8'h00, 11'd2, 11'd2, ctb_pkg::ST_DONE}},
    '{ctb_pkg::K_INSERT, "D",   10'd0,    1'b1, '{8'h00, 11'd3, 11'd3, ctb_pkg::ST_DONE}},
    '{ctb_pkg::K_INSERT, "B",   10'd0,    1'b1, '{8'h00, 11'd4, 11'd4, ctb_pkg::ST_DONE}},
    '{ctb_pkg::K_INSERT, 8'h00, 10'd0,    1'b1, '{8'h00, 11'd5, 11'd5, ctb_pkg::ST_DONE}},
    '{ctb_pkg::K_INSERT, 8'hFF, 10'd0,    1'b1, '{8'h00, 11'd6, 11'd6, ctb_pkg::ST_DONE}},
    '{ctb_pkg::K_READ,   8'h00, 10'd0,    1'b1, '{"P",   11'd6, 11'd6, ctb_pkg::ST_DONE}},
    '{ctb_pkg::K_READ,   8'h00, 10'd5,    1'b1, '{8'hFF, 11'd6, 11'd6, ctb_pkg::ST_DONE}},
    '{ctb_pkg::K_READ,   8'h00, 10'd1023, 1'b1, '{8'h00, 11'd6, 11'd6, ctb_pkg::ST_RANGE}},
    '{ctb_pkg::K_READ,   8'h00, 10'd6,    1'b1, '{8'h00, 11'd6, 11'd6, ctb_pkg::ST_RANGE}},
    '{ctb_pkg::K_LEFT,   8'h00, 10'd0,    1'b0, '0},
    '{ctb_pkg::K_LEFT,   8'h00, 10'd0,    1'b0, '0},
    '{ctb_pkg::K_READ,   8'h00, 10'd4,    1'b0, '0},
    '{ctb_pkg::K_BACK,   8'h00, 10'd0,    1'b0, '0},
    '{ctb_pkg::K_RIGHT,  8'h00, 10'd0,    1'b0, '0},
    '{ctb_pkg::K_RIGHT,  8'h00, 10'd0,    1'b0, '0},
    '{ctb_pkg::K_RIGHT,  8'h00, 10'd0,    1'b0, '0},
    '{ctb_pkg::K_READ,   8'h00, 10'd2,    1'b0, '0}
  };

  cursor_text_buffer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_char_in      (in_char_in),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_out    (out_char_out),
    .out_text_length (out_text_length),
    .out_cursor_pos  (out_cursor_pos),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic edit_line(input logic [ctb_pkg::KIND_W-1:0] kind,
                           input logic [ctb_pkg::CHAR_W-1:0] ch,
                           input logic [ctb_pkg::IDX_W-1:0] idx, output line_res_t r);
    int unsigned total;
    total = left_n + right_n;
    r = '0;
    r.st = ctb_pkg::ST_DONE;
    case (kind)
      ctb_pkg::K_INSERT: begin
        if (total >= CAP) begin
          r.st = ctb_pkg::ST_FULL;
        end else begin
          text_mem[left_n] = ch;
          left_n++;
        end
      end
      ctb_pkg::K_LEFT: begin
        if (left_n == 0) begin
          r.st = ctb_pkg::ST_IGNORED;
        end else begin
          left_n--;
          text_mem[CAP - right_n - 1] = text_mem[left_n];
          right_n++;
        end
      end
      ctb_pkg::K_RIGHT: begin
        if (right_n == 0) begin
          r.st = ctb_pkg::ST_IGNORED;
        end else begin
          text_mem[left_n] = text_mem[CAP - right_n];
          left_n++;
          right_n--;
        end
      end
      ctb_pkg::K_BACK: begin
        if (left_n == 0) r.st = ctb_pkg::ST_IGNORED;
        else left_n--;
      end
      ctb_pkg::K_READ: begin
        if (idx >= total) r.st = ctb_pkg::ST_RANGE;
        else if (idx < left_n) r.ch = text_mem[idx];
        else r.ch = text_mem[CAP - (total - idx)];
      end
      default: r.st = ctb_pkg::ST_IGNORED;
    endcase
    r.len = ctb_pkg::CNT_W'(left_n + right_n);
    r.cur = ctb_pkg::CNT_W'(left_n);
  endtask

  task automatic send_cmd(input logic [ctb_pkg::KIND_W-1:0] kind,
                          input logic [ctb_pkg::CHAR_W-1:0] ch,
                          input logic [ctb_pkg::IDX_W-1:0] idx, input logic known,
                          input line_res_t want);
    int gap;
    line_res_t got;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_char_in    <= ch;
    in_read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    edit_line(kind, ch, idx, got);
    pending_lines = {pending_lines, (known ? want : got)};
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_lines.size() != 0);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    line_res_t want;
    rx_took = 1'b0;
    if (rst_n && out_valid && out_ready) begin
      rx_took = 1'b1;
      if (pending_lines.size() == 0) begin
        $error("result item with nothing pending");
        err_count++;
      end else begin
        want = pending_lines.pop_front();
        check_field("char_out", 16'(want.ch), 16'(out_char_out));
        check_field("text_length", 16'(want.len), 16'(out_text_length));
        check_field("cursor_pos", 16'(want.cur), 16'(out_cursor_pos));
        check_field("status", 16'(want.st), 16'(out_status));
      end
    end
  end

  always @(negedge clk) begin
    if (rx_took) rx_wait = $urandom_range(0, rx_max);
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int seg_len;
    int pick;
    int sent;
    int unsigned total;
    edit_mix_t mix;
    logic [ctb_pkg::KIND_W-1:0] kind;
    logic [ctb_pkg::IDX_W-1:0] idx;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = ctb_pkg::K_INSERT;
    in_char_in = '0;
    in_read_index = '0;
    left_n = 0;
    right_n = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].kind, dir_rows[i].ch, dir_rows[i].idx, dir_rows[i].known,
               dir_rows[i].res);
    wait_drained();

    sent = 0;
    while (sent < N_RAND) begin
      seg_len = $urandom_range(8, 48);
      mix = edit_mix_t'($urandom_range(M_GROW, M_SCAN));
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      repeat (seg_len) begin
        pick = $urandom_range(0, 99);
        case (mix)
          M_GROW:
            kind = (pick < 60) ? ctb_pkg::K_INSERT : (pick < 70) ? ctb_pkg::K_LEFT :
                   (pick < 80) ? ctb_pkg::K_RIGHT : (pick < 85) ? ctb_pkg::K_BACK :
                   ctb_pkg::K_READ;
          M_EDIT:
            kind = (pick < 25) ? ctb_pkg::K_INSERT : (pick < 45) ? ctb_pkg::K_LEFT :
                   (pick < 65) ? ctb_pkg::K_RIGHT : (pick < 80) ? ctb_pkg::K_BACK :
                   (pick < 97) ? ctb_pkg::K_READ :
                   ctb_pkg::KIND_W'($urandom_range(K_SPARE_LO, K_SPARE_HI));
          M_SHRINK:
            kind = (pick < 10) ? ctb_pkg::K_INSERT : (pick < 25) ? ctb_pkg::K_LEFT :
                   (pick < 40) ? ctb_pkg::K_RIGHT : (pick < 80) ? ctb_pkg::K_BACK :
                   ctb_pkg::K_READ;
          default:
            kind = (pick < 10) ? ctb_pkg::K_INSERT : (pick < 20) ? ctb_pkg::K_LEFT :
                   (pick < 30) ? ctb_pkg::K_RIGHT : ctb_pkg::K_READ;
        endcase
        total = left_n + right_n;
        if (total != 0 && $urandom_range(0, 6) != 0)
          idx = ctb_pkg::IDX_W'($urandom_range(0, total - 1));
        else
          idx = ctb_pkg::IDX_W'($urandom_range(0, CAP - 1));
        send_cmd(kind, ctb_pkg::CHAR_W'($urandom_range(0, 255)), idx, 1'b0, '0);
        sent++;
      end
    end

    in_valid <= 1'b0;
    for (int n = 0; n < 500 && pending_lines.size() != 0; n++) @(negedge clk);
    if (pending_lines.size() != 0) begin
      $error("%0d result items never arrived", pending_lines.size());
      err_count++;
    end
    repeat (8) @(negedge clk);
    if (err_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
